// ===== hw/rtl/clns_pkg.sv =====
package clns_pkg;

  typedef enum logic [2:0] {
    ACT_INIT     = 3'd0,
    ACT_COMMAND  = 3'd1,
    ACT_CHAR     = 3'd2,
    ACT_ADDRESS  = 3'd3,
    ACT_POSITION = 3'd4,
    ACT_GLYPH    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    WAIT_NORMAL   = 2'd0,
    WAIT_EXTENDED = 2'd1,
    WAIT_POWER_UP = 2'd2,
    WAIT_INIT     = 2'd3
  } wait_e;

  typedef enum logic [2:0] {
    CFG_FUNCTION_SET    = 3'd0,
    CFG_ENTRY_MODE      = 3'd1,
    CFG_DISPLAY_CONTROL = 3'd2,
    CFG_LINE_TWO_BASE   = 3'd3,
    CFG_LINE_THREE_BASE = 3'd4,
    CFG_LINE_FOUR_BASE  = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned MaxBytes = 4;

  localparam logic [7:0] FunctionSetRst    = 8'h28;
  localparam logic [7:0] EntryModeRst      = 8'h06;
  localparam logic [7:0] DisplayControlRst = 8'h0E;
  localparam logic [6:0] LineTwoBaseRst    = 7'h40;
  localparam logic [6:0] LineThreeBaseRst  = 7'h14;
  localparam logic [6:0] LineFourBaseRst   = 7'h54;

  localparam logic [7:0] CmdClear   = 8'h01;
  localparam logic [7:0] CmdSetCgram = 8'h40;
  localparam logic [7:0] CmdSetDdram = 8'h80;

  localparam logic [3:0] InitNibbleEight = 4'h3;
  localparam logic [3:0] InitNibbleFour  = 4'h2;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic [6:0] address;
    logic [2:0] display_line;
    logic [5:0] display_column;
    logic [2:0] glyph_row;
  } req_t;

  typedef struct packed {
    logic       register_select;
    logic [3:0] nibble;
    logic [1:0] wait_code;
    logic       last_strobe;
  } strobe_t;

  typedef struct packed {
    logic                      prefix;
    logic [2:0]                nbytes;
    logic [MaxBytes-1:0]       rs;
    logic [MaxBytes-1:0][7:0]  bytes;
  } job_t;

  typedef struct packed {
    logic [7:0] function_set;
    logic [7:0] entry_mode;
    logic [7:0] display_control;
    logic [6:0] line_two_base;
    logic [6:0] line_three_base;
    logic [6:0] line_four_base;
  } cfg_t;

endpackage

// ===== hw/rtl/clns_stream_if.sv =====
interface clns_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/clns_front.sv =====
module clns_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [clns_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [clns_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               req_valid_i,
  input  clns_pkg::req_t                     req_i,
  output logic                               req_ready_o,
  input  logic                               q_full_i,
  output logic                               push_o,
  output clns_pkg::job_t                     job_o
);

  clns_pkg::cfg_t cfg_q;
  logic [6:0]     base;
  logic           pos_ok;
  logic [6:0]     pos_addr;
  clns_pkg::job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.function_set    <= clns_pkg::FunctionSetRst;
      cfg_q.entry_mode      <= clns_pkg::EntryModeRst;
      cfg_q.display_control <= clns_pkg::DisplayControlRst;
      cfg_q.line_two_base   <= clns_pkg::LineTwoBaseRst;
      cfg_q.line_three_base <= clns_pkg::LineThreeBaseRst;
      cfg_q.line_four_base  <= clns_pkg::LineFourBaseRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        clns_pkg::CFG_FUNCTION_SET:    cfg_q.function_set    <= cfg_wdata_i;
        clns_pkg::CFG_ENTRY_MODE:      cfg_q.entry_mode      <= cfg_wdata_i;
        clns_pkg::CFG_DISPLAY_CONTROL: cfg_q.display_control <= cfg_wdata_i;
        clns_pkg::CFG_LINE_TWO_BASE:   cfg_q.line_two_base   <= cfg_wdata_i[6:0];
        clns_pkg::CFG_LINE_THREE_BASE: cfg_q.line_three_base <= cfg_wdata_i[6:0];
        clns_pkg::CFG_LINE_FOUR_BASE:  cfg_q.line_four_base  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_ok = 1'b1;
    case (req_i.display_line)
      3'd1:    base = 7'd0;
      3'd2:    base = cfg_q.line_two_base;
      3'd3:    base = cfg_q.line_three_base;
      3'd4:    base = cfg_q.line_four_base;
      default: begin
        base   = 7'd0;
        pos_ok = 1'b0;
      end
    endcase
    if (req_i.display_column == 6'd0) pos_ok = 1'b0;
    pos_addr = base + {1'b0, req_i.display_column} - 7'd1;
  end

  always_comb begin
    job = '0;
    case (req_i.action)
      clns_pkg::ACT_INIT: begin
        job.prefix   = 1'b1;
        job.nbytes   = 3'd4;
        job.bytes[0] = cfg_q.function_set;
        job.bytes[1] = cfg_q.entry_mode;
        job.bytes[2] = cfg_q.display_control;
        job.bytes[3] = clns_pkg::CmdClear;
      end
      clns_pkg::ACT_COMMAND: begin
        job.nbytes   = 3'd1;
        job.bytes[0] = req_i.byte_value;
      end
      clns_pkg::ACT_CHAR: begin
        job.nbytes   = 3'd1;
        job.rs[0]    = 1'b1;
        job.bytes[0] = req_i.byte_value;
      end
      clns_pkg::ACT_ADDRESS: begin
        job.nbytes   = 3'd1;
        job.bytes[0] = clns_pkg::CmdSetDdram | {1'b0, req_i.address};
      end
      clns_pkg::ACT_POSITION: begin
        if (pos_ok) begin
          job.nbytes   = 3'd1;
          job.bytes[0] = clns_pkg::CmdSetDdram | {1'b0, pos_addr};
        end
      end
      clns_pkg::ACT_GLYPH: begin
        if (req_i.glyph_row == 3'd0) begin
          job.nbytes   = 3'd2;
          job.bytes[0] = clns_pkg::CmdSetCgram | {2'b00, req_i.address[2:0], 3'b000};
          job.rs[1]    = 1'b1;
          job.bytes[1] = req_i.byte_value;
        end else if (req_i.glyph_row == 3'd7) begin
          job.nbytes   = 3'd2;
          job.rs[0]    = 1'b1;
          job.bytes[0] = req_i.byte_value;
          job.bytes[1] = clns_pkg::CmdSetDdram;
        end else begin
          job.nbytes   = 3'd1;
          job.rs[0]    = 1'b1;
          job.bytes[0] = req_i.byte_value;
        end
      end
      default: ;
    endcase
  end

  // requests that emit nothing are accepted and dropped
  assign req_ready_o = !q_full_i;
  assign push_o      = req_valid_i && !q_full_i && (job.nbytes != 3'd0);
  assign job_o       = job;

endmodule

// ===== hw/rtl/clns_fifo.sv =====
module clns_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clns_pkg::job_t wdata_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output clns_pkg::job_t rdata_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  clns_pkg::job_t      mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d;
  logic [PtrW-1:0]     rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

// ===== hw/rtl/clns_back.sv =====
module clns_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  clns_pkg::job_t    job_i,
  output logic              pop_o,
  output logic              strobe_valid_o,
  input  logic              strobe_ready_i,
  output clns_pkg::strobe_t strobe_o
);

  logic [3:0]        step_q, step_d;
  logic              out_valid_q, out_valid_d;
  clns_pkg::strobe_t out_q, out_d;
  logic [3:0]        total;
  logic [3:0]        bstep;
  logic              in_prefix;
  logic              is_last;
  logic              advance;
  logic [7:0]        cur_byte;
  logic              cur_rs;
  clns_pkg::strobe_t cur;

  assign total     = {1'b0, job_i.prefix, 2'b00} + {job_i.nbytes, 1'b0};
  assign in_prefix = job_i.prefix && (step_q[3:2] == 2'b00);
  assign bstep     = step_q - (job_i.prefix ? 4'd4 : 4'd0);
  assign cur_byte  = job_i.bytes[bstep[2:1]];
  assign cur_rs    = job_i.rs[bstep[2:1]];
  assign is_last   = (step_q == total - 4'd1);
  assign advance   = job_valid_i && (!out_valid_q || strobe_ready_i);

  always_comb begin
    cur = '0;
    cur.last_strobe = is_last;
    if (in_prefix) begin
      case (step_q[1:0])
        2'd0: begin
          cur.nibble    = clns_pkg::InitNibbleEight;
          cur.wait_code = clns_pkg::WAIT_POWER_UP;
        end
        2'd3: begin
          cur.nibble    = clns_pkg::InitNibbleFour;
          cur.wait_code = clns_pkg::WAIT_NORMAL;
        end
        default: begin
          cur.nibble    = clns_pkg::InitNibbleEight;
          cur.wait_code = clns_pkg::WAIT_INIT;
        end
      endcase
    end else begin
      cur.register_select = cur_rs;
      if (!bstep[0]) begin
        cur.nibble    = cur_byte[7:4];
        cur.wait_code = clns_pkg::WAIT_NORMAL;
      end else begin
        cur.nibble = cur_byte[3:0];
        // clear and home need the long wait
        if (!cur_rs && (cur_byte == 8'd1 || cur_byte == 8'd2 || cur_byte == 8'd3)) begin
          cur.wait_code = clns_pkg::WAIT_EXTENDED;
        end else begin
          cur.wait_code = clns_pkg::WAIT_NORMAL;
        end
      end
    end
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_d       = cur;
      step_d      = is_last ? 4'd0 : step_q + 4'd1;
    end else if (strobe_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign pop_o          = advance && is_last;
  assign strobe_valid_o = out_valid_q;
  assign strobe_o       = out_q;

endmodule

// ===== hw/rtl/char_lcd_nibble_sequencer_top.sv =====
// Channel    Direction  Payload                                         Transaction
// req_i      in         action, byte_value, address, line, column, row  valid & ready
// strobe_o   out        register_select, nibble, wait_code, last_strobe valid & ready
// cfg        in         cfg_idx_i, cfg_wdata_i                          cfg_we_i
//
// One strobe per cycle out of the back end while the receiver is ready; a
// request yields 0, 2, 4 or 12 strobes (12 for init). Requests are
// classified combinationally and queued (QueueDepth entries), so the input
// keeps taking transactions while strobes drain, until the queue is full.
// Reset clears the queue, the step counter and the output valid and loads
// the default configuration. No clearing pass.
module char_lcd_nibble_sequencer_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [clns_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [clns_pkg::CfgDataW-1:0] cfg_wdata_i,
  clns_stream_if.sink                   req_i,
  clns_stream_if.source                 strobe_o
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  clns_pkg::job_t    q_wdata;
  clns_pkg::job_t    q_rdata;
  clns_pkg::req_t    req;
  clns_pkg::strobe_t strobe;

  assign req           = req_i.data;
  assign strobe_o.data = strobe;

  clns_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (req_i.valid),
    .req_i       (req),
    .req_ready_o (req_i.ready),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .job_o       (q_wdata)
  );

  clns_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  clns_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (q_rdata),
    .pop_o          (q_pop),
    .strobe_valid_o (strobe_o.valid),
    .strobe_ready_i (strobe_o.ready),
    .strobe_o       (strobe)
  );

`ifndef ASSERT_OFF
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_pop_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  a_ext_wait_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o.valid && strobe.wait_code == clns_pkg::WAIT_EXTENDED) |->
      (!strobe.register_select &&
       (strobe.nibble == 4'd1 || strobe.nibble == 4'd2 || strobe.nibble == 4'd3)))
    else $error("extended wait on a non-clear strobe");

  a_data_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o.valid && strobe.register_select) |->
      (strobe.wait_code == clns_pkg::WAIT_NORMAL))
    else $error("data strobe carries a wait");

  a_power_up_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o.valid && strobe_o.ready &&
     strobe.wait_code == clns_pkg::WAIT_POWER_UP) |=>
      (!strobe_o.valid || strobe.wait_code == clns_pkg::WAIT_INIT))
    else $error("power-up strobe not followed by init strobe");
`endif

endmodule

// ===== verif/char_lcd_nibble_sequencer_top_tb.sv =====
module char_lcd_nibble_sequencer_top_tb;

  localparam logic [2:0] ActSpareSix   = 3'd6;
  localparam logic [2:0] ActSpareSeven = 3'd7;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned HoldAfter     = 30;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we;
  logic [clns_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [clns_pkg::CfgDataW-1:0] cfg_wdata;

  clns_stream_if #(.T(clns_pkg::req_t))    req_if ();
  clns_stream_if #(.T(clns_pkg::strobe_t)) strobe_if ();

  char_lcd_nibble_sequencer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .strobe_o    (strobe_if)
  );

  always #5 clk_i = ~clk_i;

  clns_pkg::req_t    pending_reqs[$];
  clns_pkg::strobe_t expected_strobes[$];
  clns_pkg::strobe_t strobe_burst[$];
  clns_pkg::cfg_t    cfg_shadow;
  int      mismatches = 0;
  int      n_accepted = 0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  int      idle_cycles = 0;
  bit      quiet = 1'b0;

  task automatic push_strobe(input logic rs, input logic [3:0] nib, input clns_pkg::wait_e wc);
    clns_pkg::strobe_t s;
    s.register_select = rs;
    s.nibble          = nib;
    s.wait_code       = wc;
    s.last_strobe     = 1'b0;
    strobe_burst.push_back(s);
  endtask

  task automatic push_byte(input logic rs, input logic [7:0] b);
    clns_pkg::wait_e late;
    late = (!rs && (b == 8'h01 || b == 8'h02 || b == 8'h03)) ?
           clns_pkg::WAIT_EXTENDED : clns_pkg::WAIT_NORMAL;
    push_strobe(rs, b[7:4], clns_pkg::WAIT_NORMAL);
    push_strobe(rs, b[3:0], late);
  endtask

  task automatic predict_strobes(input clns_pkg::req_t r);
    logic [6:0]        base;
    logic [6:0]        ddram;
    logic              hit;
    clns_pkg::strobe_t s;
    strobe_burst.delete();
    case (r.action)
      clns_pkg::ACT_INIT: begin
        push_strobe(1'b0, clns_pkg::InitNibbleEight, clns_pkg::WAIT_POWER_UP);
        push_strobe(1'b0, clns_pkg::InitNibbleEight, clns_pkg::WAIT_INIT);
        push_strobe(1'b0, clns_pkg::InitNibbleEight, clns_pkg::WAIT_INIT);
        push_strobe(1'b0, clns_pkg::InitNibbleFour, clns_pkg::WAIT_NORMAL);
        push_byte(1'b0, cfg_shadow.function_set);
        push_byte(1'b0, cfg_shadow.entry_mode);
        push_byte(1'b0, cfg_shadow.display_control);
        push_byte(1'b0, clns_pkg::CmdClear);
      end
      clns_pkg::ACT_COMMAND: push_byte(1'b0, r.byte_value);
      clns_pkg::ACT_CHAR: push_byte(1'b1, r.byte_value);
      clns_pkg::ACT_ADDRESS: push_byte(1'b0, clns_pkg::CmdSetDdram | {1'b0, r.address});
      clns_pkg::ACT_POSITION: begin
        hit = 1'b1;
        base = '0;
        case (r.display_line)
          3'd1: base = '0;
          3'd2: base = cfg_shadow.line_two_base;
          3'd3: base = cfg_shadow.line_three_base;
          3'd4: base = cfg_shadow.line_four_base;
          default: hit = 1'b0;
        endcase
        if (r.display_column == '0) hit = 1'b0;
        ddram = base + 7'(r.display_column) - 7'd1;
        if (hit) push_byte(1'b0, clns_pkg::CmdSetDdram | {1'b0, ddram});
      end
      clns_pkg::ACT_GLYPH: begin
        if (r.glyph_row == 3'd0)
          push_byte(1'b0, clns_pkg::CmdSetCgram | {2'b00, r.address[2:0], 3'b000});
        push_byte(1'b1, r.byte_value);
        if (r.glyph_row == 3'd7) push_byte(1'b0, clns_pkg::CmdSetDdram);
      end
      default: ;
    endcase
    if (strobe_burst.size() > 0) begin
      s = strobe_burst[strobe_burst.size()-1];
      s.last_strobe = 1'b1;
      strobe_burst[strobe_burst.size()-1] = s;
    end
    foreach (strobe_burst[i]) expected_strobes.push_back(strobe_burst[i]);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_strobes(pending_reqs.pop_front());
        n_accepted <= n_accepted + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 3);
          req_if.valid <= 1'b0;
        end else begin
          req_if.valid <= 1'b1;
          req_if.data <= pending_reqs[0];
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      strobe_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (strobe_if.valid && strobe_if.ready) begin
        if (expected_strobes.size() == 0) begin
          $error("unexpected strobe %p", strobe_if.data);
          mismatches++;
        end else begin
          clns_pkg::strobe_t want;
          want = expected_strobes.pop_front();
          if (strobe_if.data.register_select !== want.register_select) begin
            $error("register_select expected %0d actual %0d",
                   want.register_select, strobe_if.data.register_select);
            mismatches++;
          end
          if (strobe_if.data.nibble !== want.nibble) begin
            $error("nibble expected %0h actual %0h", want.nibble, strobe_if.data.nibble);
            mismatches++;
          end
          if (strobe_if.data.wait_code !== want.wait_code) begin
            $error("wait_code expected %0d actual %0d", want.wait_code, strobe_if.data.wait_code);
            mismatches++;
          end
          if (strobe_if.data.last_strobe !== want.last_strobe) begin
            $error("last_strobe expected %0d actual %0d",
                   want.last_strobe, strobe_if.data.last_strobe);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        strobe_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        strobe_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 3);
        strobe_if.ready <= 1'b0;
      end else begin
        strobe_if.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the request queue backs up
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HoldAfter) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (strobe_if.valid && strobe_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input clns_pkg::cfg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_config(input logic [7:0] fs, input logic [7:0] em, input logic [7:0] dc,
                             input logic [6:0] b2, input logic [6:0] b3, input logic [6:0] b4);
    write_reg(clns_pkg::CFG_FUNCTION_SET, fs);
    write_reg(clns_pkg::CFG_ENTRY_MODE, em);
    write_reg(clns_pkg::CFG_DISPLAY_CONTROL, dc);
    write_reg(clns_pkg::CFG_LINE_TWO_BASE, {1'b0, b2});
    write_reg(clns_pkg::CFG_LINE_THREE_BASE, {1'b0, b3});
    write_reg(clns_pkg::CFG_LINE_FOUR_BASE, {1'b0, b4});
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cfg_shadow = '{fs, em, dc, b2, b3, b4};
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_if.valid || expected_strobes.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic clns_pkg::req_t make_req(input logic [2:0] act, input logic [7:0] b,
                                              input logic [6:0] addr, input logic [2:0] line,
                                              input logic [5:0] col, input logic [2:0] row);
    clns_pkg::req_t r;
    r.action         = act;
    r.byte_value     = b;
    r.address        = addr;
    r.display_line   = line;
    r.display_column = col;
    r.glyph_row      = row;
    return r;
  endfunction

  function automatic clns_pkg::req_t random_req();
    clns_pkg::req_t r;
    int             pick;
    r = make_req(clns_pkg::ACT_INIT, 8'($urandom), 7'($urandom), 3'($urandom),
                 6'($urandom), 3'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r.action = clns_pkg::ACT_INIT;
    end else if (pick < 25) begin
      r.action = clns_pkg::ACT_COMMAND;
      if ($urandom_range(0, 3) == 0) r.byte_value = 8'($urandom_range(0, 4));
    end else if (pick < 45) begin
      r.action = clns_pkg::ACT_CHAR;
    end else if (pick < 55) begin
      r.action = clns_pkg::ACT_ADDRESS;
    end else if (pick < 77) begin
      r.action = clns_pkg::ACT_POSITION;
      if ($urandom_range(0, 4) != 0) r.display_line = 3'($urandom_range(1, 4));
      if ($urandom_range(0, 9) == 0) r.display_column = '0;
    end else if (pick < 95) begin
      r.action = clns_pkg::ACT_GLYPH;
    end else begin
      r.action = $urandom_range(0, 1) ? ActSpareSix : ActSpareSeven;
    end
    return r;
  endfunction

  task automatic queue_random(input int n);
    int             cnt;
    clns_pkg::req_t r;
    logic [6:0]     slot_addr;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) == 0) begin
        // a complete glyph: rows 0..7 into one slot
        slot_addr = 7'($urandom);
        for (int row = 0; row < 8; row++) begin
          pending_reqs.push_back(make_req(clns_pkg::ACT_GLYPH, 8'($urandom), slot_addr,
                                          3'($urandom), 6'($urandom), 3'(row)));
        end
        cnt += 8;
      end else begin
        r = random_req();
        pending_reqs.push_back(r);
        if (r.action != ActSpareSix && r.action != ActSpareSeven &&
            !(r.action == clns_pkg::ACT_POSITION && (r.display_line == 3'd0 ||
              r.display_line > 3'd4 || r.display_column == '0)))
          cnt++;
      end
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    strobe_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    cfg_shadow = '{clns_pkg::FunctionSetRst, clns_pkg::EntryModeRst,
                   clns_pkg::DisplayControlRst, clns_pkg::LineTwoBaseRst,
                   clns_pkg::LineThreeBaseRst, clns_pkg::LineFourBaseRst};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset configuration
    pending_reqs.push_back(make_req(clns_pkg::ACT_INIT, 8'h00, 7'h00, 3'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_COMMAND, 8'h00, 7'h00, 3'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_COMMAND, 8'hFF, 7'h7F, 3'd7, 6'd63, 3'd7));
    pending_reqs.push_back(make_req(clns_pkg::ACT_COMMAND, 8'h01, 7'h00, 3'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_COMMAND, 8'h02, 7'h00, 3'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_COMMAND, 8'h03, 7'h00, 3'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_COMMAND, 8'h04, 7'h00, 3'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_CHAR, 8'h00, 7'h00, 3'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_CHAR, 8'hFF, 7'h7F, 3'd7, 6'd63, 3'd7));
    pending_reqs.push_back(make_req(clns_pkg::ACT_CHAR, 8'h01, 7'h00, 3'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_ADDRESS, 8'h00, 7'h00, 3'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_ADDRESS, 8'h00, 7'h7F, 3'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_POSITION, 8'h00, 7'h00, 3'd1, 6'd1, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_POSITION, 8'h00, 7'h00, 3'd2, 6'd63, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_POSITION, 8'h00, 7'h00, 3'd4, 6'd63, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_POSITION, 8'h00, 7'h00, 3'd3, 6'd20, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_POSITION, 8'h00, 7'h00, 3'd0, 6'd5, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_POSITION, 8'h00, 7'h00, 3'd5, 6'd5, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_POSITION, 8'h00, 7'h00, 3'd2, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_GLYPH, 8'hAA, 7'h7F, 3'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::ACT_GLYPH, 8'h55, 7'h00, 3'd0, 6'd0, 3'd3));
    pending_reqs.push_back(make_req(clns_pkg::ACT_GLYPH, 8'h1F, 7'h00, 3'd0, 6'd0, 3'd7));
    pending_reqs.push_back(make_req(ActSpareSix, 8'h00, 7'h00, 3'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(ActSpareSeven, 8'hFF, 7'h7F, 3'd7, 6'd63, 3'd7));
    wait_drained();

    load_config(8'h00, 8'h00, 8'h00, 7'h00, 7'h00, 7'h00);
    queue_random(60);
    wait_drained();

    load_config(8'hFF, 8'hFF, 8'hFF, 7'h7F, 7'h7F, 7'h7F);
    queue_random(60);
    wait_drained();

    // init bytes that need the extended wait
    load_config(8'h01, 8'h02, 8'h03, 7'($urandom), 7'($urandom), 7'($urandom));
    queue_random(60);
    wait_drained();

    quiet = 1'b1;
    load_config(8'($urandom), 8'($urandom), 8'($urandom),
                7'($urandom), 7'($urandom), 7'($urandom));
    queue_random(60);
    wait_drained();

    if (mismatches == 0 && expected_strobes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
